// ===== hw/rtl/matrix_multiply_4x4_macros.svh =====
// Assertion macros for the 4x4 matrix multiplier
`ifndef MATRIX_MULTIPLY_4X4_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_MACROS_SVH
// assert that a property holds after reset
`define MM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// assert that a signal holds its value in the next cycle
`define MM_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) cond |=> $stable(sig)) \
    else $error(msg);
`endif

// ===== hw/rtl/mm4_pkg.sv =====
// Package: types, constants and arithmetic helpers of the matrix multiplier
`default_nettype none
package mm4_pkg;
  localparam int unsigned DefDim      = 4;
  localparam int unsigned DefFracBits = 16;
  localparam int unsigned ValW        = 32;
  localparam int unsigned IdxW        = 4;

  typedef enum logic {
    FUNC_LOAD_LEFT  = 1'b0,
    FUNC_LOAD_RIGHT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_e;

  // control from the sequencer to each cell
  typedef struct packed {
    logic clear;   // start a new dot product
    logic mac;     // accumulate the term at the head of the rows
    logic shift;   // shift the result chain by one cell
  } cell_ctrl_t;

  // clamp a 33-bit signed sum to 32 bits
  function automatic logic signed [ValW-1:0] sat_add(logic signed [ValW-1:0] a,
                                                     logic signed [ValW-1:0] b);
    logic signed [ValW:0] s;
    s = {a[ValW-1], a} + {b[ValW-1], b};
    if (s[ValW] != s[ValW-1]) sat_add = s[ValW] ? {1'b1, {(ValW-1){1'b0}}}
                                                : {1'b0, {(ValW-1){1'b1}}};
    else sat_add = s[ValW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/mm4_cell.sv =====
// One cell: a multiply-accumulate for one product element, chained for output
`default_nettype none
module mm4_cell
  import mm4_pkg::*;
#(
  parameter int unsigned FracBits = DefFracBits
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic signed [ValW-1:0]  a_i,
  input  wire logic signed [ValW-1:0]  b_i,
  input  wire logic signed [ValW-1:0]  chain_i,
  output logic signed [ValW-1:0]       acc_o
);
  logic signed [2*ValW-1:0] prod_q, prod_d;
  logic                     pv_q, pv_d;
  logic signed [ValW-1:0]   acc_q, acc_d;
  logic signed [2*ValW-1:0] shf;
  logic signed [ValW-1:0]   term;

  // floor shift and clamp of the registered product
  always_comb begin
    shf = prod_q >>> FracBits;
    if (shf > 64'sd2147483647) term = {1'b0, {(ValW-1){1'b1}}};
    else if (shf < -64'sd2147483648) term = {1'b1, {(ValW-1){1'b0}}};
    else term = shf[ValW-1:0];
  end

  always_comb begin
    prod_d = a_i * b_i;
    pv_d   = ctrl_i.mac;
    acc_d  = acc_q;
    if (ctrl_i.clear) acc_d = '0;
    else if (pv_q) acc_d = sat_add(acc_q, term);
    else if (ctrl_i.shift) acc_d = chain_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

// ===== hw/rtl/matrix_multiply_4x4.sv =====
// Start: a right beat at the last position starts the product in the Dim*Dim
// chained multiply-accumulate cells; then Dim*Dim result beats follow, one per
// cycle while m_axis_tready is high. Input: one load beat per cycle, only while
// idle; no new beat is taken until the last result beat has gone out.
// Reset: the left matrix clears to zero, control returns to idle.
`default_nettype none
module matrix_multiply_4x4
  import mm4_pkg::*;
#(
  parameter int unsigned Dim      = DefDim,
  parameter int unsigned FracBits = DefFracBits
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // [3:0] elem_index, [35:4] elem_value
  input  wire         s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [3:0] out_index, [35:4] out_value
  output logic        m_axis_tlast    // out_last
);
  localparam int unsigned NElem = Dim * Dim;
  localparam int unsigned EW    = $clog2(Dim);
  localparam int unsigned KW    = $clog2(NElem);
  localparam int unsigned CW    = $clog2(Dim + 3);

  logic signed [ValW-1:0] left_q  [NElem];
  logic signed [ValW-1:0] right_q [NElem];
  logic signed [ValW-1:0] acc     [NElem];
  logic signed [ValW-1:0] a_w     [NElem];
  logic signed [ValW-1:0] b_w     [NElem];
  logic signed [ValW-1:0] ch_w    [NElem];

  state_e      state_q, state_d;
  logic [CW-1:0] step_q, step_d;
  logic [KW:0]   cnt_q, cnt_d;
  cell_ctrl_t    ctrl;

  logic [IdxW-1:0]        in_idx;
  logic signed [ValW-1:0] in_val;
  logic                   acc_in, in_ok;

  assign in_idx = s_axis_tdata[IdxW-1:0];
  assign in_val = s_axis_tdata[IdxW+ValW-1:IdxW];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign in_ok  = ({1'b0, in_idx} < (IdxW+1)'(NElem));

  // sequence the dot product steps and the output sweep
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    ctrl    = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc_in && in_ok && s_axis_tuser == FUNC_LOAD_RIGHT &&
            {1'b0, in_idx} == (IdxW+1)'(NElem - 1)) begin
          state_d    = ST_CALC;
          step_d     = '0;
          ctrl.clear = 1'b1;
        end
      end
      ST_CALC: begin
        ctrl.mac = (step_q < CW'(Dim));
        step_d   = step_q + 1'b1;
        if (step_q == CW'(Dim + 1)) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end
      end
      ST_EMIT: begin
        if (m_axis_tready) begin
          ctrl.shift = 1'b1;
          cnt_d      = cnt_q + 1'b1;
          if (cnt_q == (KW+1)'(NElem - 1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  // hold the matrices; the product replaces the left matrix during the sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NElem; i++) left_q[i] <= '0;
    end else if (state_q == ST_EMIT && m_axis_tready) begin
      left_q[cnt_q[KW-1:0]] <= acc[0];
    end else if (acc_in && in_ok && s_axis_tuser == FUNC_LOAD_LEFT) begin
      left_q[in_idx[KW-1:0]] <= in_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in && in_ok && s_axis_tuser == FUNC_LOAD_RIGHT)
      right_q[in_idx[KW-1:0]] <= in_val;
  end

  // row of cells; cell k computes product position k
  for (genvar k = 0; k < NElem; k++) begin : g_cell
    localparam int unsigned R = k % Dim;
    localparam int unsigned C = k / Dim;
    assign a_w[k]  = left_q[KW'(R + Dim * int'(step_q[EW-1:0]))];
    assign b_w[k]  = right_q[KW'(int'(step_q[EW-1:0]) + Dim * C)];
    assign ch_w[k] = (k == NElem - 1) ? acc[k] : acc[(k + 1) % NElem];
    mm4_cell #(.FracBits(FracBits)) u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl),
      .a_i(a_w[k]), .b_i(b_w[k]), .chain_i(ch_w[k]), .acc_o(acc[k])
    );
  end

  assign m_axis_tvalid = (state_q == ST_EMIT);
  assign m_axis_tdata  = {4'b0, acc[0], IdxW'(cnt_q[KW-1:0])};
  assign m_axis_tlast  = (cnt_q == (KW+1)'(NElem - 1));

  `include "matrix_multiply_4x4_macros.svh"
  `MM_ASSERT(a_no_accept_busy, (state_q != ST_IDLE) |-> !s_axis_tready, "busy input")
  `MM_ASSERT(a_last_in_emit, m_axis_tlast && m_axis_tvalid |-> state_q == ST_EMIT, "bad last")
  `MM_ASSERT_HOLD(a_hold_out, (m_axis_tvalid && !m_axis_tready), m_axis_tdata, "out moved")
endmodule
`default_nettype wire
